FILE: rtl/kfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kfi_pkg;

  localparam int unsigned QW = 32;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_EVAL   = 2'd2,
    REQ_NONE   = 2'd3
  } kfi_req_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } kfi_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_EV0_RD,
    ST_EV0_CHK,
    ST_EVL_RD,
    ST_EVL_CHK,
    ST_EV_RD,
    ST_EV_CHK,
    ST_DIV,
    ST_DONE
  } kfi_state_t;

  // handshake between sequencer and scaled divider
  typedef struct packed {
    logic            start;
    logic [QW-1:0]   m;
    logic [QW-1:0]   n;
    logic [QW-1:0]   s;
  } kfi_div_req_t;

  typedef struct packed {
    logic            done;
    logic [QW-1:0]   q;
  } kfi_div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/kfi_store.sv
`timescale 1ns / 1ps
`default_nettype none
module kfi_store
  import kfi_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = 16,
  localparam int unsigned AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic [AW-1:0]        rd_addr,
  output logic signed [QW-1:0]      rd_time,
  output logic signed [QW-1:0]      rd_value,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic signed [QW-1:0] wr_time,
  input  wire logic signed [QW-1:0] wr_value
);

  logic signed [QW-1:0] time_mem  [KEY_DEPTH];
  logic signed [QW-1:0] value_mem [KEY_DEPTH];

  // write one key pair
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= wr_time;
      value_mem[wr_addr] <= wr_value;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_time  <= time_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/kfi_sqdiv.sv
`timescale 1ns / 1ps
`default_nettype none
module kfi_sqdiv
  import kfi_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kfi_div_req_t  req,
  output kfi_div_rsp_t       rsp
);

  localparam int unsigned CNTW = $clog2(QW);

  // floor(m * n / s) with n <= s, one bit of m per cycle, remainder kept below s
  logic [QW-1:0]          m_r, m_nxt;
  logic [QW-1:0]          n_r, n_nxt;
  logic [QW-1:0]          s_r, s_nxt;
  logic [QW-1:0]          r_r, r_nxt;
  logic [QW-1:0]          q_r, q_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  logic [QW+2:0] acc;
  logic [QW+2:0] d1;
  logic [QW+2:0] d2;

  always_comb begin
    acc = {2'b00, r_r, 1'b0} + (m_r[QW-1] ? {3'b000, n_r} : '0);
    d1  = acc - {3'b000, s_r};
    d2  = acc - {2'b00, s_r, 1'b0};
    m_nxt    = m_r;
    n_nxt    = n_r;
    s_nxt    = s_r;
    r_nxt    = r_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      m_nxt    = req.m;
      n_nxt    = req.n;
      s_nxt    = req.s;
      r_nxt    = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // double, add n when the bit is set, then take off 2s or s when it fits
      m_nxt = {m_r[QW-2:0], 1'b0};
      if (!d2[QW+2]) begin
        r_nxt = d2[QW-1:0];
        q_nxt = {q_r[QW-2:0], 1'b0} + QW'(2);
      end else if (!d1[QW+2]) begin
        r_nxt = d1[QW-1:0];
        q_nxt = {q_r[QW-2:0], 1'b1};
      end else begin
        r_nxt = acc[QW-1:0];
        q_nxt = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    n_r <= n_nxt;
    s_r <= s_nxt;
    r_r <= r_nxt;
    q_r <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule
`default_nettype wire

FILE: rtl/keyframe_track_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  req_type, key_time, key_value, eval_time
// out      output     out_valid/out_stall result_value, status, key_count
// cfg      input      cfg_wr_en          cfg_wr_data (step_mode)
//
// One request at a time; clear, unknown, full insert and empty evaluate go straight to
// the output. Insert scans the keys and moves the later ones up through the one read
// port. Evaluate returns the first key's value at or before the first key, the last
// key's value at or after the last key, else interpolates between the bracketing pair
// in the divider, or returns the lower key's value in step mode.
// Synchronous active-low reset empties the track and clears step mode; a stalled
// output register holds the finished request and so the input.
module keyframe_track_interpolator_unit
  import kfi_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_req_type,
  input  wire logic signed [31:0] in_key_time,
  input  wire logic signed [31:0] in_key_value,
  input  wire logic signed [31:0] in_eval_time,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [31:0]     out_result_value,
  output logic [1:0]             out_status,
  output logic [4:0]             out_key_count,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data
);

  localparam int unsigned AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(KEY_DEPTH + 1);

  kfi_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          step_r;
  logic          ovalid_r, ovalid_nxt;

  logic signed [QW-1:0] kt_r, kt_nxt, kv_r, kv_nxt, et_r, et_nxt;
  logic signed [QW-1:0] pt_r, pt_nxt, pv_r, pv_nxt;
  logic signed [QW-1:0] res_r, res_nxt;
  kfi_status_t          sts_r, sts_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [QW-1:0] ores_r, ores_nxt;
  kfi_status_t          osts_r, osts_nxt;
  logic [CW-1:0]        ocnt_r, ocnt_nxt;

  logic [AW-1:0]        rd_addr;
  logic signed [QW-1:0] rd_time, rd_value;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [QW-1:0] wr_time, wr_value;

  kfi_div_req_t dreq;
  kfi_div_rsp_t drsp;

  logic signed [QW:0] span, num, diff, numc;
  logic [CW-1:0]      last;
  logic [31:0]        ocnt_ext;

  kfi_store #(.KEY_DEPTH(KEY_DEPTH)) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_value(rd_value),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_time (wr_time),
    .wr_value(wr_value)
  );

  kfi_sqdiv u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // interval arithmetic on the bracketing pair
  always_comb begin
    last = count_r - 1'b1;
    span = {rd_time[QW-1], rd_time} - {pt_r[QW-1], pt_r};
    num  = {et_r[QW-1], et_r} - {pt_r[QW-1], pt_r};
    diff = {rd_value[QW-1], rd_value} - {pv_r[QW-1], pv_r};
    if (num[QW]) numc = '0;
    else if (num > span) numc = span;
    else numc = num;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    j_nxt      = j_r;
    kt_nxt     = kt_r;
    kv_nxt     = kv_r;
    et_nxt     = et_r;
    pt_nxt     = pt_r;
    pv_nxt     = pv_r;
    res_nxt    = res_r;
    sts_nxt    = sts_r;
    neg_nxt    = neg_r;
    ovalid_nxt = ovalid_r && out_stall;
    ores_nxt   = ores_r;
    osts_nxt   = osts_r;
    ocnt_nxt   = ocnt_r;
    rd_addr    = idx_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = j_r[AW-1:0];
    wr_time    = rd_time;
    wr_value   = rd_value;
    dreq.start = 1'b0;
    dreq.m     = diff[QW] ? QW'(-diff) : diff[QW-1:0];
    dreq.n     = numc[QW-1:0];
    dreq.s     = span[QW-1:0];
    in_stall   = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kt_nxt  = in_key_time;
          kv_nxt  = in_key_value;
          et_nxt  = in_eval_time;
          res_nxt = '0;
          sts_nxt = STS_OK;
          idx_nxt = '0;
          state_nxt = ST_DONE;
          case (kfi_req_t'(in_req_type))
            REQ_CLEAR: count_nxt = '0;
            REQ_INSERT: begin
              if (count_r >= CW'(KEY_DEPTH)) sts_nxt = STS_FULL;
              else state_nxt = ST_INS_RD;
            end
            REQ_EVAL: begin
              if (count_r == '0) sts_nxt = STS_EMPTY;
              else state_nxt = ST_EV0_RD;
            end
            default: ;
          endcase
        end
      end
      // find the slot after every key of time <= new time
      ST_INS_RD: begin
        if (idx_r == count_r) begin
          j_nxt     = count_r;
          state_nxt = ST_SH_RD;
        end else begin
          state_nxt = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (rd_time <= kt_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_INS_RD;
        end else begin
          j_nxt     = count_r;
          state_nxt = ST_SH_RD;
        end
      end
      // move later keys up by one, then drop the new key into its slot
      ST_SH_RD: begin
        if (j_r > idx_r) begin
          rd_addr   = AW'(j_r - 1'b1);
          state_nxt = ST_SH_WR;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = idx_r[AW-1:0];
          wr_time   = kt_r;
          wr_value  = kv_r;
          count_nxt = count_r + 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_SH_WR: begin
        wr_en     = 1'b1;
        j_nxt     = j_r - 1'b1;
        state_nxt = ST_SH_RD;
      end
      // before or at the first key
      ST_EV0_RD: begin
        rd_addr   = '0;
        state_nxt = ST_EV0_CHK;
      end
      ST_EV0_CHK: begin
        pt_nxt = rd_time;
        pv_nxt = rd_value;
        if (count_r == CW'(1) || et_r <= rd_time) begin
          res_nxt   = rd_value;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_EVL_RD;
        end
      end
      // at or after the last key
      ST_EVL_RD: begin
        rd_addr   = last[AW-1:0];
        state_nxt = ST_EVL_CHK;
      end
      ST_EVL_CHK: begin
        if (et_r >= rd_time) begin
          res_nxt   = rd_value;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = CW'(1);
          state_nxt = ST_EV_RD;
        end
      end
      // walk to the first key not before the evaluation time
      ST_EV_RD: begin
        state_nxt = ST_EV_CHK;
      end
      ST_EV_CHK: begin
        if (rd_time < et_r && idx_r < last) begin
          pt_nxt    = rd_time;
          pv_nxt    = rd_value;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_EV_RD;
        end else if (step_r) begin
          res_nxt   = pv_r;
          state_nxt = ST_DONE;
        end else if (span[QW] || span == '0) begin
          res_nxt   = rd_value;
          state_nxt = ST_DONE;
        end else begin
          neg_nxt    = diff[QW];
          dreq.start = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          res_nxt   = neg_r ? pv_r - drsp.q : pv_r + drsp.q;
          state_nxt = ST_DONE;
        end
      end
      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          ores_nxt   = res_r;
          osts_nxt   = sts_r;
          ocnt_nxt   = count_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      step_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr_en) step_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    j_r    <= j_nxt;
    kt_r   <= kt_nxt;
    kv_r   <= kv_nxt;
    et_r   <= et_nxt;
    pt_r   <= pt_nxt;
    pv_r   <= pv_nxt;
    res_r  <= res_nxt;
    sts_r  <= sts_nxt;
    neg_r  <= neg_nxt;
    ores_r <= ores_nxt;
    osts_r <= osts_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign ocnt_ext         = 32'(ocnt_r);
  assign out_valid        = ovalid_r;
  assign out_result_value = ores_r;
  assign out_status       = osts_r;
  assign out_key_count    = ocnt_ext[4:0];

endmodule
`default_nettype wire
